// ===== rtl/trie_distinct_id_counter_defines.svh =====
// Assertion macros shared by the checker of the trie counter.
`ifndef TRIE_DISTINCT_ID_COUNTER_DEFINES_SVH
`define TRIE_DISTINCT_ID_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TDIC_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("trie counter check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TDIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("trie counter check failed");

`endif

// ===== rtl/tdic_pkg.sv =====
package tdic_pkg;

  localparam int unsigned NODE_COUNT = 4096;
  localparam int unsigned ALPHABET   = 26;

  localparam int unsigned NODE_W = $clog2(NODE_COUNT);
  localparam int unsigned SYM_W  = 5;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned CNT_W  = 16;

  // One link row holds the children of a node, one field per letter.
  localparam int unsigned ROW_W  = ALPHABET * NODE_W;
  // One count word holds the last seen id above the count.
  localparam int unsigned WORD_W = ID_W + CNT_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND  = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef logic [ALPHABET-1:0][NODE_W-1:0] link_row_t;

endpackage

// ===== rtl/tdic_ram.sv =====
module tdic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/trie_distinct_id_counter.sv =====
// A word is taken in S_IDLE and goes to S_LINK, then to S_CNT when an insert reaches an existing
// node or a query's last letter finds its node, as the count word is read and then used.
// No word is taken outside S_IDLE; a result strobe is registered in S_LINK or, if found, S_CNT.
// Each step reads the single-port link row memory, and for S_CNT the count memory as well.
// After reset the block clears all 4096 rows of both memories, one row a cycle, with busy_o high.
// The receiver cannot stall; each result is shown for exactly one cycle.
module trie_distinct_id_counter import tdic_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             kind_i,
  input  logic             restart_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic [ID_W-1:0]  string_id_i,
  input  logic             last_i,
  output logic             valid_o,
  output logic [CNT_W-1:0] count_o,
  output logic [1:0]       status_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LINK  = 4'b0100,
    S_CNT   = 4'b1000
  } state_e;

  state_e state_q;
  logic [NODE_W-1:0] clr_q;
  logic [NODE_W-1:0] cursor_q;
  logic              dead_q;
  logic [NODE_W-1:0] nodes_used_q;
  logic              out_valid_q;

  logic             kind_q;
  logic [SYM_W-1:0] sym_q;
  logic [ID_W-1:0]  id_q;
  logic             last_q;
  logic [CNT_W-1:0] count_q;
  status_e          status_q;

  logic              accept;
  logic [NODE_W-1:0] cursor_eff;
  logic              dead_eff;

  logic              link_we;
  logic [NODE_W-1:0] link_addr;
  logic [ROW_W-1:0]  link_wdata;
  logic [ROW_W-1:0]  link_rdata;
  logic              cnt_we;
  logic [NODE_W-1:0] cnt_addr;
  logic [WORD_W-1:0] cnt_wdata;
  logic [WORD_W-1:0] cnt_rdata;

  link_row_t         link_row;
  link_row_t         new_row;
  logic              sym_ok;
  logic [NODE_W-1:0] next_node;
  logic [NODE_W-1:0] alloc_node;
  logic              table_full;
  logic              ins_go;
  logic              ins_alloc;
  logic              ins_full;
  logic              qry_hit;
  logic [ID_W-1:0]   seen_old;
  logic [CNT_W-1:0]  cnt_old;
  logic [CNT_W-1:0]  cnt_new;
  logic [CNT_W-1:0]  cnt_fresh;

  assign busy_o     = (state_q != S_IDLE);
  assign accept     = start_i && (state_q == S_IDLE);
  assign cursor_eff = restart_i ? '0 : cursor_q;
  assign dead_eff   = restart_i ? 1'b0 : dead_q;

  assign link_row   = link_rdata;
  assign sym_ok     = (sym_q < SYM_W'(ALPHABET));
  assign next_node  = sym_ok ? link_row[sym_q] : '0;
  assign alloc_node = nodes_used_q + 1'b1;
  assign table_full = (nodes_used_q == NODE_W'(NODE_COUNT - 1));

  assign ins_go    = (kind_q == KIND_INSERT) && !dead_q && sym_ok;
  assign ins_alloc = ins_go && (next_node == '0) && !table_full;
  assign ins_full  = ins_go && (next_node == '0) && table_full;
  assign qry_hit   = (kind_q == KIND_QUERY) && !dead_q && sym_ok && (next_node != '0);

  assign seen_old  = cnt_rdata[CNT_W +: ID_W];
  assign cnt_old   = cnt_rdata[CNT_W-1:0];
  assign cnt_new   = ((seen_old != id_q) && (cnt_old != COUNT_MAX)) ? cnt_old + 1'b1 : cnt_old;
  // A fresh node has last seen id zero, so only a nonzero id counts on it.
  assign cnt_fresh = (id_q != '0) ? CNT_W'(1) : '0;

  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      new_row[i] = (SYM_W'(i) == sym_q) ? alloc_node : link_row[i];
    end
  end

  always_comb begin
    link_we    = 1'b0;
    link_addr  = cursor_eff;
    link_wdata = new_row;
    cnt_we     = 1'b0;
    cnt_addr   = next_node;
    cnt_wdata  = {id_q, cnt_new};
    case (state_q)
      S_CLEAR: begin
        link_we    = 1'b1;
        link_addr  = clr_q;
        link_wdata = '0;
        cnt_we     = 1'b1;
        cnt_addr   = clr_q;
        cnt_wdata  = '0;
      end
      S_IDLE: begin
        link_addr = cursor_eff;
      end
      S_LINK: begin
        if (ins_alloc) begin
          link_we   = 1'b1;
          link_addr = cursor_q;
          cnt_we    = 1'b1;
          cnt_addr  = alloc_node;
          cnt_wdata = {id_q, cnt_fresh};
        end
      end
      S_CNT: begin
        cnt_addr = cursor_q;
        cnt_we   = (kind_q == KIND_INSERT);
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      cursor_q     <= '0;
      dead_q       <= 1'b0;
      nodes_used_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == NODE_W'(NODE_COUNT - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cursor_q <= cursor_eff;
            dead_q   <= dead_eff;
            state_q  <= S_LINK;
          end
        end
        S_LINK: begin
          state_q <= S_IDLE;
          if (kind_q == KIND_INSERT) begin
            if (!dead_q && !sym_ok) begin
              dead_q <= 1'b1;
            end else if (ins_full) begin
              dead_q      <= 1'b1;
              out_valid_q <= 1'b1;
            end else if (ins_alloc) begin
              nodes_used_q <= alloc_node;
              cursor_q     <= alloc_node;
            end else if (ins_go) begin
              cursor_q <= next_node;
              state_q  <= S_CNT;
            end
          end else if (qry_hit) begin
            cursor_q <= next_node;
            if (last_q) begin
              state_q <= S_CNT;
            end
          end else begin
            dead_q      <= 1'b1;
            out_valid_q <= last_q;
          end
        end
        S_CNT: begin
          state_q     <= S_IDLE;
          out_valid_q <= (kind_q == KIND_QUERY);
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The word fields and the result payload need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      sym_q  <= symbol_i;
      id_q   <= string_id_i;
      last_q <= last_i;
    end
    if (state_q == S_LINK) begin
      count_q  <= '0;
      status_q <= ins_full ? ST_FULL : ST_ABSENT;
    end else if (state_q == S_CNT) begin
      count_q  <= cnt_old;
      status_q <= ST_FOUND;
    end
  end

  assign valid_o  = out_valid_q;
  assign count_o  = count_q;
  assign status_o = status_q;

  tdic_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NODE_COUNT)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .addr_i (link_addr),
    .wdata_i(link_wdata),
    .rdata_o(link_rdata)
  );

  tdic_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NODE_COUNT)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .addr_i (cnt_addr),
    .wdata_i(cnt_wdata),
    .rdata_o(cnt_rdata)
  );

endmodule

// ===== rtl/tdic_checker.sv =====
`include "trie_distinct_id_counter_defines.svh"

module tdic_checker import tdic_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_i,
  input logic             valid_i,
  input logic [CNT_W-1:0] count_i,
  input logic [1:0]       status_i
);

  // An accepted word keeps the block busy for at least the next cycle.
  `TDIC_ASSERT_NEXT(a_accept_busy, start_i && !busy_i, busy_i)

  // A word causes at most one result, so strobes never come in adjacent cycles.
  `TDIC_ASSERT_NEXT(a_single_strobe, valid_i, !valid_i)

  // Results appear once the block has returned to idle.
  `TDIC_ASSERT(a_result_idle, valid_i, !busy_i)

  // Absent paths and a full table report a zero count.
  `TDIC_ASSERT(a_zero_count, valid_i && (status_i != ST_FOUND), count_i == '0)

endmodule

bind trie_distinct_id_counter tdic_checker u_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_i  (busy_o),
  .valid_i (valid_o),
  .count_i (count_o),
  .status_i(status_o)
);
